[hw/rtl/deq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Storage geometry, beat layouts, operation and status codes, and the
// circular index helper used by the pointer logic.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH    = 16;
   localparam int WIDTH    = 32;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4
   } deq_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } deq_status_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } deq_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_data;
      logic [COUNT_W-1:0]        element_count;
      logic [STATUS_W-1:0]       status;
   } deq_rsp_type;

   // Result of the decision stage, waiting for the memory read data.
   typedef struct packed {
      logic           use_mem;
      logic [CNT_W-1:0] count;
      deq_status_type status;
   } deq_issue_type;

   // Circular add of an offset below DEPTH to a slot index.
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] offset);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (ADDR_W+1)'(DEPTH)) begin
         sum = sum - (ADDR_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/deq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic single-port synchronous RAM
// One access per cycle at a single address, a write, a read or both, with the read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic                          re,
   input  wire logic [$clog2(DEPTH)-1:0]      addr,
   input  wire logic [WIDTH-1:0]              wdata,
   output      logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[hw/rtl/deq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: head pointer, fill count and memory access decision
// Decides each operation in its accept cycle, updates the pointers and
// drives the single memory access the operation needs, if it needs one.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire deq_pkg::deq_req_type          req,
   output      logic                          ram_we,
   output      logic                          ram_re,
   output      logic [deq_pkg::ADDR_W-1:0]    ram_addr,
   output      logic [deq_pkg::WIDTH-1:0]     ram_wdata,
   output      deq_pkg::deq_issue_type        issue
);

   logic [deq_pkg::ADDR_W-1:0] head_ff, head_in;
   logic [deq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       full, empty;
   logic [deq_pkg::ADDR_W-1:0] back_slot, last_slot, pos_slot, prev_head;

   assign full      = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign back_slot = deq_pkg::wrap_add(head_ff, deq_pkg::ADDR_W'(count_ff));
   assign last_slot = deq_pkg::wrap_add(head_ff, deq_pkg::ADDR_W'(count_ff - 1'b1));
   assign pos_slot  = deq_pkg::wrap_add(head_ff, deq_pkg::ADDR_W'(req.position));
   assign prev_head = (head_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                      : head_ff - 1'b1;

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_addr      = head_ff;
      ram_wdata     = deq_pkg::WIDTH'(unsigned'(req.value));
      issue.use_mem = 1'b0;
      issue.status  = deq_pkg::ST_OK;
      unique case (deq_pkg::deq_op_type'(req.operation))
         deq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               issue.status = deq_pkg::ST_FULL;
            end else begin
               ram_we   = take;
               ram_addr = back_slot;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               issue.status = deq_pkg::ST_FULL;
            end else begin
               ram_we   = take;
               ram_addr = prev_head;
               head_in  = prev_head;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               issue.status = deq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               issue.status = deq_pkg::ST_EMPTY;
            end else begin
               head_in  = deq_pkg::wrap_add(head_ff, deq_pkg::ADDR_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_READ: begin
            if (deq_pkg::CMP_W'(req.position) < deq_pkg::CMP_W'(count_ff)) begin
               ram_re        = take;
               ram_addr      = pos_slot;
               issue.use_mem = 1'b1;
            end else begin
               issue.status = deq_pkg::ST_RANGE;
               if (!empty) begin
                  ram_re        = take;
                  ram_addr      = last_slot;
                  issue.use_mem = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      issue.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (take) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/deq_resp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_resp: read-data stage and result register
// Joins the decision with the memory read data and holds the result beat
// until it is taken.
// ----------------------------------------------------------------------------
module deq_resp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire deq_pkg::deq_issue_type        issue,
   input  wire logic [deq_pkg::WIDTH-1:0]     ram_rdata,
   output      logic                          open,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      deq_pkg::deq_rsp_type          rsp_data
);

   logic                   s1_valid_ff, s1_valid_in;
   deq_pkg::deq_issue_type s1_issue_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   deq_pkg::deq_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   advance;

   // The memory output only changes on a new read, which needs this stage open.
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign open    = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in.read_data     = s1_issue_ff.use_mem
                                  ? deq_pkg::VALUE_W'(ram_rdata) : '0;
      rsp_data_in.element_count = deq_pkg::COUNT_W'(s1_issue_ff.count);
      rsp_data_in.status        = s1_issue_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_issue_ff <= issue;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[hw/rtl/double_ended_queue.sv]
`default_nettype none
// Path: an accepted beat's decision and memory read data are held in the read-data stage and then
// move into the result register, which holds the result beat until the consumer takes it.
// Throughput: one beat per cycle, sustained while the consumer takes results, set by the single
// memory port, which every operation uses at most once.
// Reset clears the head pointer and the fill count; the element memory is not
// cleared, since no entry is read before it is written.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a circular buffer
// Pushes and pops at either end and indexed reads, with full, empty and
// out-of-range status reported on every result beat.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire deq_pkg::deq_req_type  req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      deq_pkg::deq_rsp_type  rsp_data
);

   // A request beat is taken whenever the read-data stage is free or moves
   // on in the same cycle, so a stalled result never blocks more than one
   // extra beat in flight.
   logic                        take;
   logic                        open;
   logic                        ram_we, ram_re;
   logic [deq_pkg::ADDR_W-1:0]  ram_addr;
   logic [deq_pkg::WIDTH-1:0]   ram_wdata, ram_rdata;
   deq_pkg::deq_issue_type      issue;

   assign req_ready = open;
   assign take      = req_valid && req_ready;

   // Pointer and count logic. Each operation is decided in its accept cycle,
   // so the next beat sees the updated head and count without any bypass.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .issue     (issue)
   );

   // Element storage. A write and a later read of the same slot fall in
   // different cycles, so the registered read always returns current data.
   deq_ram #(
      .WIDTH (deq_pkg::WIDTH),
      .DEPTH (deq_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Read-data stage and the result register that faces the consumer.
   deq_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .issue     (issue),
      .ram_rdata (ram_rdata),
      .open      (open),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.element_count <= deq_pkg::COUNT_W'(deq_pkg::DEPTH)))
      else $error("element count beyond capacity");

   // A full rejection is only reported with a full store.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == deq_pkg::ST_FULL)
      |-> (rsp_data.element_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH)))
      else $error("full status with room left");

   // An empty rejection is only reported with an empty store.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == deq_pkg::ST_EMPTY)
      |-> (rsp_data.element_count == '0))
      else $error("empty status with elements stored");

   // An out-of-range read of an empty store returns zero.
   a_range_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == deq_pkg::ST_RANGE
       && rsp_data.element_count == '0) |-> (rsp_data.read_data == '0))
      else $error("data returned from an empty store");

endmodule
`default_nettype wire
